/* rtl/core/per_key_sample_statistics_defines.svh */
// Assertion macros for the per-key sample statistics block.
// Used by the checker module; no other dependencies.
`ifndef PER_KEY_SAMPLE_STATISTICS_DEFINES_SVH
`define PER_KEY_SAMPLE_STATISTICS_DEFINES_SVH

// Clocked assertion, disabled during reset.
`define PKSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that a value holds while a handshake is stalled.
`define PKSS_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
    `PKSS_ASSERT(lbl, vld && !rdy |=> $stable(sig), msg)

`endif

/* rtl/core/pkss_pkg.sv */
// Package for the per-key sample statistics block: sizes, command codes,
// item types and the queue entry. No dependencies.
package pkss_pkg;

    localparam int NUM_KEYS    = 64;
    localparam int KEY_W       = 6;
    localparam int RD_W        = 16;
    localparam int SUM_W       = 48;
    localparam int SQ_W        = 64;
    localparam int CNT_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_W       = 64;
    localparam int DIVCNT_W    = $clog2(DIV_W);
    localparam int SQRT_STEPS  = 16;
    localparam int SQRTCNT_W   = $clog2(SQRT_STEPS);

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [KEY_W-1:0] key_index;
        logic [RD_W-1:0] reading;
        logic            frame_end;
    } req_t;

    typedef struct packed {
        logic [15:0]      rep_min;
        logic [15:0]      rep_max;
        logic [15:0]      rep_diff;
        logic [15:0]      rep_stddev;
        logic [CNT_W-1:0] rep_count;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CLEAR,
        OP_REPORT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key_index;
        logic [RD_W-1:0]  reading;
        logic             frame_end;
    } work_t;

endpackage

/* rtl/core/pkss_front.sv */
// Front end: accepts request items, decodes the command and queues work.
// Depends on pkss_pkg.
module pkss_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pkss_pkg::req_t req,
    output logic           work_valid,
    input  logic           work_ready,
    output pkss_pkg::work_t work
);

    pkss_pkg::work_t                   queue_reg [pkss_pkg::QUEUE_DEPTH];
    logic [pkss_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [pkss_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [pkss_pkg::QCNT_W-1:0]       cnt_reg;
    pkss_pkg::work_t                   entry_next;
    logic                              known;
    logic                              push;
    logic                              pop;

    always_comb
    begin
        entry_next.key_index = req.key_index;
        entry_next.reading   = req.reading;
        entry_next.frame_end = req.frame_end;
        known                = 1'b1;
        case (req.cmd)
            pkss_pkg::CMD_SAMPLE: entry_next.op = pkss_pkg::OP_SAMPLE;
            pkss_pkg::CMD_CLEAR:  entry_next.op = pkss_pkg::OP_CLEAR;
            pkss_pkg::CMD_REPORT: entry_next.op = pkss_pkg::OP_REPORT;
            default:
            begin
                entry_next.op = pkss_pkg::OP_SAMPLE;
                known         = 1'b0;
            end
        endcase
    end

    assign req_ready  = (cnt_reg != pkss_pkg::QCNT_W'(pkss_pkg::QUEUE_DEPTH));
    assign push       = req_valid && req_ready && known;
    assign work_valid = (cnt_reg != '0);
    assign pop        = work_valid && work_ready;
    assign work       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/pkss_back.sv */
// Back end: per-key statistics memories, sample update, window clear and
// report sequencer (bit-serial divide, multiply, bit-serial square root).
// Depends on pkss_pkg.
module pkss_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            work_valid,
    output logic            work_ready,
    input  pkss_pkg::work_t work,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pkss_pkg::rsp_t  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL,
        S_VAR,
        S_SQRT,
        S_DONE
    } state_t;

    localparam logic [pkss_pkg::CNT_W-1:0] COUNT_MAX = '1;

    logic [pkss_pkg::RD_W-1:0]  min_mem [pkss_pkg::NUM_KEYS];
    logic [pkss_pkg::RD_W-1:0]  max_mem [pkss_pkg::NUM_KEYS];
    logic [pkss_pkg::SUM_W-1:0] sum_mem [pkss_pkg::NUM_KEYS];
    logic [pkss_pkg::SQ_W-1:0]  sq_mem  [pkss_pkg::NUM_KEYS];

    logic [pkss_pkg::RD_W-1:0]  min_q_reg;
    logic [pkss_pkg::RD_W-1:0]  max_q_reg;
    logic [pkss_pkg::SUM_W-1:0] sum_q_reg;
    logic [pkss_pkg::SQ_W-1:0]  sq_q_reg;

    logic [pkss_pkg::NUM_KEYS-1:0] mm_vld_reg;
    logic [pkss_pkg::NUM_KEYS-1:0] sum_vld_reg;
    logic                          rd_mm_vld_reg;
    logic                          rd_sum_vld_reg;

    state_t                        state_reg;
    pkss_pkg::work_t               cur_reg;
    logic [pkss_pkg::CNT_W-1:0]    count_reg;
    logic                          first_reg;

    logic [pkss_pkg::DIV_W-1:0]    dvd_a_reg;
    logic [pkss_pkg::DIV_W-1:0]    dvd_b_reg;
    logic [31:0]                   rem_a_reg;
    logic [31:0]                   rem_b_reg;
    logic [31:0]                   quo_a_reg;
    logic [31:0]                   quo_b_reg;
    logic [31:0]                   divisor_reg;
    logic [pkss_pkg::DIVCNT_W-1:0] div_cnt_reg;
    logic [31:0]                   prod_reg;
    logic [31:0]                   v_reg;
    logic [31:0]                   root_reg;
    logic [31:0]                   bit_reg;
    logic [pkss_pkg::SQRTCNT_W-1:0] sq_cnt_reg;
    logic [pkss_pkg::RD_W-1:0]     rmin_reg;
    logic [pkss_pkg::RD_W-1:0]     rmax_reg;
    logic [pkss_pkg::CNT_W-1:0]    rcount_reg;

    logic                          rsp_valid_reg;
    pkss_pkg::rsp_t                rsp_reg;

    logic                          key_ok;
    logic [pkss_pkg::RD_W-1:0]     base_min;
    logic [pkss_pkg::RD_W-1:0]     base_max;
    logic [pkss_pkg::SUM_W-1:0]    base_sum;
    logic [pkss_pkg::SQ_W-1:0]     base_sq;
    logic [pkss_pkg::RD_W-1:0]     min_next;
    logic [pkss_pkg::RD_W-1:0]     max_next;
    logic [pkss_pkg::SUM_W-1:0]    sum_next;
    logic [pkss_pkg::SQ_W-1:0]     sq_next;
    logic [31:0]                   rd_sq;
    logic                          mem_we;
    logic [32:0]                   trial_a;
    logic [32:0]                   trial_b;
    logic                          qbit_a;
    logic                          qbit_b;
    logic [31:0]                   sq_trial;

    assign work_ready = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign key_ok   = (32'(cur_reg.key_index) < pkss_pkg::NUM_KEYS);
    assign base_min = rd_mm_vld_reg ? min_q_reg : '0;
    assign base_max = rd_mm_vld_reg ? max_q_reg : '0;
    assign base_sum = rd_sum_vld_reg ? sum_q_reg : '0;
    assign base_sq  = rd_sum_vld_reg ? sq_q_reg : '0;
    assign rd_sq    = cur_reg.reading * cur_reg.reading;

    always_comb
    begin
        min_next = (first_reg || cur_reg.reading < base_min) ? cur_reg.reading : base_min;
        max_next = (first_reg || cur_reg.reading > base_max) ? cur_reg.reading : base_max;
        if (count_reg != COUNT_MAX)
        begin
            sum_next = base_sum + pkss_pkg::SUM_W'(cur_reg.reading);
            sq_next  = base_sq + pkss_pkg::SQ_W'(rd_sq);
        end
        else
        begin
            sum_next = base_sum;
            sq_next  = base_sq;
        end
    end

    assign mem_we = (state_reg == S_READ) && (cur_reg.op == pkss_pkg::OP_SAMPLE) && key_ok;

    assign trial_a  = {rem_a_reg, dvd_a_reg[pkss_pkg::DIV_W-1]};
    assign trial_b  = {rem_b_reg, dvd_b_reg[pkss_pkg::DIV_W-1]};
    assign qbit_a   = (trial_a >= {1'b0, divisor_reg});
    assign qbit_b   = (trial_b >= {1'b0, divisor_reg});
    assign sq_trial = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            min_mem[cur_reg.key_index] <= min_next;
            max_mem[cur_reg.key_index] <= max_next;
            sum_mem[cur_reg.key_index] <= sum_next;
            sq_mem[cur_reg.key_index]  <= sq_next;
        end
        if (state_reg == S_IDLE)
        begin
            min_q_reg <= min_mem[work.key_index];
            max_q_reg <= max_mem[work.key_index];
            sum_q_reg <= sum_mem[work.key_index];
            sq_q_reg  <= sq_mem[work.key_index];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mm_vld_reg     <= '0;
            sum_vld_reg    <= '0;
            rd_mm_vld_reg  <= 1'b0;
            rd_sum_vld_reg <= 1'b0;
            count_reg      <= '0;
            first_reg      <= 1'b1;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    rd_mm_vld_reg  <= mm_vld_reg[work.key_index];
                    rd_sum_vld_reg <= sum_vld_reg[work.key_index];
                    if (work_valid)
                    begin
                        cur_reg <= work;
                        if (work.op == pkss_pkg::OP_CLEAR)
                        begin
                            sum_vld_reg <= '0;
                            count_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    if (cur_reg.op == pkss_pkg::OP_SAMPLE)
                    begin
                        if (key_ok)
                        begin
                            mm_vld_reg[cur_reg.key_index]  <= 1'b1;
                            sum_vld_reg[cur_reg.key_index] <= 1'b1;
                        end
                        if (cur_reg.frame_end)
                        begin
                            first_reg <= 1'b0;
                            if (count_reg != COUNT_MAX)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        rmin_reg    <= key_ok ? base_min : '0;
                        rmax_reg    <= key_ok ? base_max : '0;
                        rcount_reg  <= count_reg;
                        dvd_a_reg   <= key_ok ? pkss_pkg::DIV_W'(base_sum) : '0;
                        dvd_b_reg   <= key_ok ? pkss_pkg::DIV_W'(base_sq) : '0;
                        divisor_reg <= (count_reg == '0) ? 32'd1 : count_reg;
                        rem_a_reg   <= '0;
                        rem_b_reg   <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_a_reg   <= qbit_a ? 32'(trial_a - {1'b0, divisor_reg}) : trial_a[31:0];
                    rem_b_reg   <= qbit_b ? 32'(trial_b - {1'b0, divisor_reg}) : trial_b[31:0];
                    quo_a_reg   <= {quo_a_reg[30:0], qbit_a};
                    quo_b_reg   <= {quo_b_reg[30:0], qbit_b};
                    dvd_a_reg   <= {dvd_a_reg[pkss_pkg::DIV_W-2:0], 1'b0};
                    dvd_b_reg   <= {dvd_b_reg[pkss_pkg::DIV_W-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == '1)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= quo_a_reg * quo_a_reg;
                    state_reg <= S_VAR;
                end
                S_VAR:
                begin
                    v_reg      <= (quo_b_reg > prod_reg) ? quo_b_reg - prod_reg : '0;
                    root_reg   <= '0;
                    bit_reg    <= 32'h4000_0000;
                    sq_cnt_reg <= '0;
                    state_reg  <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (v_reg >= sq_trial)
                    begin
                        v_reg    <= v_reg - sq_trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg    <= bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == '1)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.rep_min    <= rmin_reg;
                        rsp_reg.rep_max    <= rmax_reg;
                        rsp_reg.rep_diff   <= rmax_reg - rmin_reg;
                        rsp_reg.rep_stddev <= root_reg[15:0];
                        rsp_reg.rep_count  <= rcount_reg;
                        rsp_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/per_key_sample_statistics.sv */
// Top level of the per-key sample statistics block.
// Depends on pkss_pkg, pkss_front and pkss_back.
//
// Keeps min, max, sum and sum of squares for each of 64 keys plus one shared
// frame count. Request items enter a 4-entry queue; unused commands are
// dropped there. The back end takes one item at a time: a sample does a
// memory read, then a read-modify-write; a reset-window clears the valid
// bits in one step; and a report runs the 64-step bit-serial divider, one
// multiply and the 16-step square root. A finished report waits in an
// output register while the queue keeps accepting. Reset takes effect at
// once; no clearing pass is needed.
module per_key_sample_statistics (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pkss_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pkss_pkg::rsp_t rsp
);

    logic            work_valid;
    logic            work_ready;
    pkss_pkg::work_t work;

    pkss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .work_valid (work_valid),
        .work_ready (work_ready),
        .work       (work)
    );

    pkss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work_ready (work_ready),
        .work       (work),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

/* rtl/core/pkss_checker.sv */
// Port-level checks for per_key_sample_statistics, bound to the top level.
// Depends on pkss_pkg and per_key_sample_statistics_defines.svh.
`include "per_key_sample_statistics_defines.svh"

module pkss_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input pkss_pkg::rsp_t rsp
);

    `PKSS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp item dropped")
    `PKSS_ASSERT_HOLD(a_rsp_stable, rsp_valid, rsp_ready, rsp, "rsp item changed while stalled")
    `PKSS_ASSERT(a_rsp_diff, rsp_valid |-> rsp.rep_diff == rsp.rep_max - rsp.rep_min, "bad diff")
    `PKSS_ASSERT(a_req_hold, req_valid && !req_ready |=> req_valid, "req item withdrawn")

endmodule

bind per_key_sample_statistics pkss_checker u_pkss_checker (.*);

/* verif/testbench.sv */
// Testbench for per_key_sample_statistics: random and directed sample, window-clear
// and report items checked against a built-in predictor. Depends on pkss_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    pkss_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    pkss_pkg::rsp_t rsp;
    logic req_taken;

    per_key_sample_statistics DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    // predictor state
    logic [15:0]                st_min [pkss_pkg::NUM_KEYS];
    logic [15:0]                st_max [pkss_pkg::NUM_KEYS];
    logic [pkss_pkg::SUM_W-1:0] st_sum [pkss_pkg::NUM_KEYS];
    logic [pkss_pkg::SQ_W-1:0]  st_sq [pkss_pkg::NUM_KEYS];
    logic [31:0]                st_frames;
    logic                       st_first;

    pkss_pkg::req_t pending_items[$];
    pkss_pkg::rsp_t expected_reports[$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   errors;
    int   reports_seen;
    int   items_sent;
    int   quiet_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] isqrt(input logic [31:0] v);
        logic [31:0] res;
        logic [31:0] root;
        res = '0;
        for (int b = 15; b >= 0; b--)
        begin
            root = res | (32'd1 << b);
            if (root * root <= v)
                res = root;
        end
        return res;
    endfunction

    task automatic predict(input pkss_pkg::req_t it);
        logic [63:0] c;
        logic [31:0] mean;
        logic [31:0] mean_sq;
        logic [31:0] sqm;
        logic [31:0] var_v;
        pkss_pkg::rsp_t r;
        case (it.cmd)
            pkss_pkg::CMD_SAMPLE:
            begin
                if (st_first || it.reading < st_min[it.key_index])
                    st_min[it.key_index] = it.reading;
                if (st_first || it.reading > st_max[it.key_index])
                    st_max[it.key_index] = it.reading;
                if (st_frames != 32'hFFFF_FFFF)
                begin
                    st_sum[it.key_index] = st_sum[it.key_index] + it.reading;
                    st_sq[it.key_index] = st_sq[it.key_index] + it.reading * it.reading;
                end
                if (it.frame_end)
                begin
                    st_first = 1'b0;
                    if (st_frames != 32'hFFFF_FFFF)
                        st_frames = st_frames + 1;
                end
            end
            pkss_pkg::CMD_CLEAR:
            begin
                for (int k = 0; k < pkss_pkg::NUM_KEYS; k++)
                begin
                    st_sum[k] = '0;
                    st_sq[k] = '0;
                end
                st_frames = '0;
            end
            pkss_pkg::CMD_REPORT:
            begin
                c = (st_frames == 0) ? 64'd1 : {32'd0, st_frames};
                mean = 32'({16'd0, st_sum[it.key_index]} / c);
                mean_sq = 32'(st_sq[it.key_index] / c);
                sqm = mean * mean;
                var_v = (mean_sq > sqm) ? mean_sq - sqm : 32'd0;
                r.rep_min = st_min[it.key_index];
                r.rep_max = st_max[it.key_index];
                r.rep_diff = r.rep_max - r.rep_min;
                r.rep_stddev = 16'(isqrt(var_v));
                r.rep_count = st_frames;
                expected_reports.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    function automatic pkss_pkg::req_t make_item(input logic [1:0] cmd, input int key,
                                                 input int rd, input bit fe);
        pkss_pkg::req_t it;
        it.cmd = cmd;
        it.key_index = pkss_pkg::KEY_W'(key);
        it.reading = pkss_pkg::RD_W'(rd);
        it.frame_end = fe;
        return it;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req <= pending_items.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_valid && req_ready;
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req_valid && req_ready)
            begin
                predict(req);
                items_sent <= items_sent + 1;
            end
            if (rsp_valid && rsp_ready)
            begin
                reports_seen <= reports_seen + 1;
                if (expected_reports.size() == 0)
                begin
                    report_mismatch("unexpected report", 32'd1, 32'd0);
                end
                else
                begin
                    pkss_pkg::rsp_t e;
                    e = expected_reports.pop_front();
                    if (rsp.rep_min !== e.rep_min)
                        report_mismatch("rep_min", rsp.rep_min, e.rep_min);
                    if (rsp.rep_max !== e.rep_max)
                        report_mismatch("rep_max", rsp.rep_max, e.rep_max);
                    if (rsp.rep_diff !== e.rep_diff)
                        report_mismatch("rep_diff", rsp.rep_diff, e.rep_diff);
                    if (rsp.rep_stddev !== e.rep_stddev)
                        report_mismatch("rep_stddev", rsp.rep_stddev, e.rep_stddev);
                    if (rsp.rep_count !== e.rep_count)
                        report_mismatch("rep_count", rsp.rep_count, e.rep_count);
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || req_valid || expected_reports.size() > 0)
            @(posedge clk);
    endtask

    task automatic add_random_items(input int n);
        int r;
        int k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            k = $urandom_range(7) == 0 ? $urandom_range(63) : $urandom_range(7);
            if (r < 70)
                pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, k,
                    $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(255),
                    $urandom_range(7) == 0));
            else if (r < 90)
                pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, k,
                    $urandom_range(65535), $urandom_range(1)));
            else if (r < 95)
                pending_items.push_back(make_item(pkss_pkg::CMD_CLEAR, k,
                    $urandom_range(65535), $urandom_range(1)));
            else
                pending_items.push_back(make_item(CMD_UNUSED, k, $urandom_range(65535),
                    $urandom_range(1)));
        end
    endtask

    initial
    begin
        errors = 0;
        reports_seen = 0;
        items_sent = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_valid = 1'b0;
        req_taken = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        for (int k = 0; k < pkss_pkg::NUM_KEYS; k++)
        begin
            st_min[k] = '0;
            st_max[k] = '0;
            st_sum[k] = '0;
            st_sq[k] = '0;
        end
        st_frames = '0;
        st_first = 1'b1;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        // directed: report before any sample, first frame, extremes
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 0, 16'hFFFF, 1));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 0, 1000, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 0, 10, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 63, 16'hFFFF, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 63, 0, 1));
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 0, 0, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 63, 0, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 1, 16'hFFFF, 1));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 1, 0, 1));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 1, 16'hFFFF, 1));
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 1, 16'hFFFF, 1));
        pending_items.push_back(make_item(CMD_UNUSED, 2, 5, 1));
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 1, 0, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_CLEAR, 63, 16'hFFFF, 1));
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 1, 0, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_SAMPLE, 1, 16'h8000, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 1, 0, 0));
        pending_items.push_back(make_item(pkss_pkg::CMD_REPORT, 42, 16'h5555, 0));
        drain();
        // hold off until everything has come, then resume
        repeat (100) @(posedge clk);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random_items(300);
        drain();
        send_idle_pct = 72;
        add_random_items(250);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 72;
        add_random_items(250);
        drain();
        send_idle_pct = 23;
        recv_stall_pct = 23;
        add_random_items(300);
        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d items, %0d reports over four idling phases",
                 items_sent, reports_seen);
        if (errors == 0 && expected_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
